[sv/assert_macros.svh]
// Assertion macros shared by the sight trace clipper RTL.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STC_ASSERT(lbl, prop, msg)
`define STC_NEVER(lbl, cond, msg)
`endif
`endif

[sv/stc_pkg.sv]
// Shared widths, limits and saturation helpers for the sight trace clipper.
// No dependencies.
package stc_pkg;

    localparam int MUL_W  = 18;
    localparam int NUM_W  = 56;
    localparam int DEN_W  = 40;
    localparam int FRAC_W = 15;

    localparam logic signed [NUM_W-1:0] FRAC_LO    = 56'sd4;
    localparam logic signed [NUM_W-1:0] FRAC_HI    = 56'sd65536;
    localparam logic signed [NUM_W-1:0] SLOPE_QMAX = 56'sd8388607;
    localparam logic signed [NUM_W-1:0] SLOPE_QMIN = -56'sd8388608;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic [2:0] top;
        top = v[33:31];
        if (top == 3'b000 || top == 3'b111)
        begin
            return v[31:0];
        end
        else if (v[33])
        begin
            return S32_MIN;
        end
        else
        begin
            return S32_MAX;
        end
    endfunction

    function automatic logic signed [31:0] slope_sat(input logic signed [NUM_W-1:0] q);
        if (q > SLOPE_QMAX)
        begin
            return S32_MAX;
        end
        else if (q < SLOPE_QMIN)
        begin
            return S32_MIN;
        end
        else
        begin
            return {q[23:0], 8'h00};
        end
    endfunction

endpackage

[sv/stc_mul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on stc_pkg for its default width.
module stc_mul #(
    parameter int W = stc_pkg::MUL_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic                  busy,
    output logic                  done,
    output logic signed [2*W-1:0] product
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [2*W-1:0] acc_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W-1:0]   a_mag;
    logic [W-1:0]   b_mag;

    assign a_mag = a[W-1] ? W'(-a) : W'(a);
    assign b_mag = b[W-1] ? W'(-b) : W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= {{W{1'b0}}, a_mag};
            mplier_reg <= b_mag;
            acc_reg    <= '0;
            neg_reg    <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

[sv/stc_div.sv]
// Bit-serial restoring signed divider, one quotient bit per cycle, truncating to zero.
// Depends on stc_pkg for its default widths.
module stc_div #(
    parameter int NW = stc_pkg::NUM_W,
    parameter int DW = stc_pkg::DEN_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic signed [DW-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic signed [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] n_mag;
    logic [DW-1:0] d_mag;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign n_mag = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
    assign d_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= n_mag;
            rem_reg <= '0;
            dvs_reg <= d_mag;
            neg_reg <= dividend[NW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

[sv/sight_trace_segment_clipper_core.sv]
// Sight trace segment clipper top level; uses stc_pkg, stc_mul, stc_div, assert_macros.svh.
// A start item goes through ST_START1 and ST_START2 to ST_DONE, and a segment on a blocked trace
// goes straight to ST_DONE. Any other segment runs eight products on the bit-serial multiplier,
// then up to three quotients on the bit-serial divider. One item is worked at a time, and an
// untaken result holds off the next one.
// Reset is asynchronous: trace state clears to zero and the trace reads as unobstructed.
`include "assert_macros.svh"
module sight_trace_segment_clipper_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic               two_sided,
    input  logic signed [31:0] z_a,
    input  logic signed [31:0] z_b,
    input  logic signed [31:0] z_c,
    input  logic signed [31:0] z_d,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible,
    output logic signed [31:0] top_slope_out,
    output logic signed [31:0] bottom_slope_out
);

    localparam int MW = stc_pkg::MUL_W;
    localparam int NW = stc_pkg::NUM_W;
    localparam int DW = stc_pkg::DEN_W;
    localparam int FW = stc_pkg::FRAC_W;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_START1  = 10'b0000000010,
        ST_START2  = 10'b0000000100,
        ST_MUL     = 10'b0000001000,
        ST_EVAL    = 10'b0000010000,
        ST_DIVF    = 10'b0000100000,
        ST_SLOPE_B = 10'b0001000000,
        ST_SLOPE_T = 10'b0010000000,
        ST_FINAL   = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic               two_sided_reg;
    logic signed [31:0] za_reg, zb_reg, zc_reg, zd_reg;

    logic signed [31:0] eye_reg, eye_next;
    logic signed [31:0] top_reg, top_next;
    logic signed [31:0] bot_reg, bot_next;
    logic signed [15:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [15:0] tx_reg, tx_next, ty_reg, ty_next;
    logic               blocked_reg, blocked_next;

    logic [2:0]              step_reg, step_next;
    logic signed [2*MW-1:0]  prod_reg [0:7];
    logic                    mstart_reg, mstart_next;
    logic                    dstart_reg, dstart_next;
    logic signed [NW-1:0]    dn_reg, dn_next;
    logic signed [DW-1:0]    dd_reg, dd_next;
    logic [FW-1:0]           f_reg;

    logic               out_valid_reg, out_valid_next;
    logic               visible_reg;
    logic signed [31:0] top_out_reg, bot_out_reg;

    logic                   accept;
    logic                   out_load;
    logic signed [16:0]     tdx, tdy, dx1, dy1, dx2, dy2, nx, ny, ex, ey;
    logic signed [16:0]     op_a, op_b;
    logic                   mul_busy, mul_done;
    logic signed [2*MW-1:0] mul_p;
    logic                   div_busy, div_done;
    logic signed [NW-1:0]   div_q;
    logic signed [36:0]     pr1, pr2;
    logic signed [37:0]     den;
    logic                   side1, side2;
    logic signed [31:0]     obot, otop;
    logic signed [32:0]     hb_diff, ht_diff;
    logic signed [33:0]     eye_sum, top_sum, bot_sum;
    logic signed [31:0]     slope_new;
    logic [FW-1:0]          f_cur;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign tdx = 17'(tx_reg) - 17'(lx_reg);
    assign tdy = 17'(ty_reg) - 17'(ly_reg);
    assign dx1 = 17'(ax_reg) - 17'(lx_reg);
    assign dy1 = 17'(ay_reg) - 17'(ly_reg);
    assign dx2 = 17'(bx_reg) - 17'(lx_reg);
    assign dy2 = 17'(by_reg) - 17'(ly_reg);
    assign nx  = 17'(ay_reg) - 17'(by_reg);
    assign ny  = 17'(bx_reg) - 17'(ax_reg);
    assign ex  = 17'(tx_reg) - 17'(ax_reg);
    assign ey  = 17'(ty_reg) - 17'(ay_reg);

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                op_a = tdy;
                op_b = dx2;
            end
            3'd1:
            begin
                op_a = dy2;
                op_b = tdx;
            end
            3'd2:
            begin
                op_a = tdy;
                op_b = dx1;
            end
            3'd3:
            begin
                op_a = dy1;
                op_b = tdx;
            end
            3'd4:
            begin
                op_a = nx;
                op_b = dx1;
            end
            3'd5:
            begin
                op_a = ny;
                op_b = dy1;
            end
            3'd6:
            begin
                op_a = nx;
                op_b = ex;
            end
            default:
            begin
                op_a = ny;
                op_b = ey;
            end
        endcase
    end

    stc_mul #(
        .W(MW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart_reg),
        .a       (MW'(op_a)),
        .b       (MW'(op_b)),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    stc_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart_reg),
        .dividend (dn_reg),
        .divisor  (dd_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign side2 = prod_reg[0] < prod_reg[1];
    assign side1 = prod_reg[2] < prod_reg[3];
    assign pr1   = 37'(prod_reg[4]) + 37'(prod_reg[5]);
    assign pr2   = 37'(prod_reg[6]) + 37'(prod_reg[7]);
    assign den   = 38'(pr1) + 38'(pr2);

    assign obot    = (za_reg > zc_reg) ? za_reg : zc_reg;
    assign otop    = (zb_reg < zd_reg) ? zb_reg : zd_reg;
    assign hb_diff = 33'(obot) - 33'(eye_reg);
    assign ht_diff = 33'(otop) - 33'(eye_reg);
    assign f_cur   = div_q[FW+1:2];

    assign eye_sum   = 34'(za_reg) + 34'(zb_reg) - 34'(zb_reg >>> 2);
    assign top_sum   = 34'(zc_reg) + 34'(zd_reg) - 34'(eye_reg);
    assign bot_sum   = 34'(zc_reg) - 34'(eye_reg);
    assign slope_new = stc_pkg::slope_sat(div_q);

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        eye_next       = eye_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        blocked_next   = blocked_reg;
        step_next      = step_reg;
        mstart_next    = 1'b0;
        dstart_next    = 1'b0;
        dn_next        = dn_reg;
        dd_next        = dd_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!func)
                    begin
                        state_next = ST_START1;
                    end
                    else if (blocked_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next  = ST_MUL;
                        step_next   = 3'd0;
                        mstart_next = 1'b1;
                    end
                end
            end
            ST_START1:
            begin
                lx_next    = {ax_reg[15:1], 1'b1};
                ly_next    = {ay_reg[15:1], 1'b1};
                tx_next    = {bx_reg[15:1], 1'b1};
                ty_next    = {by_reg[15:1], 1'b1};
                eye_next   = stc_pkg::sat34(eye_sum);
                state_next = ST_START2;
            end
            ST_START2:
            begin
                top_next     = stc_pkg::sat34(top_sum);
                bot_next     = stc_pkg::sat34(bot_sum);
                blocked_next = 1'b0;
                state_next   = ST_DONE;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (step_reg == 3'd7)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        step_next   = step_reg + 3'd1;
                        mstart_next = 1'b1;
                    end
                end
            end
            ST_EVAL:
            begin
                if (side1 == side2 || den == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dn_next     = NW'(pr1) <<< 16;
                    dd_next     = DW'(den);
                    dstart_next = 1'b1;
                    state_next  = ST_DIVF;
                end
            end
            ST_DIVF:
            begin
                if (div_done)
                begin
                    if (div_q < stc_pkg::FRAC_LO || div_q > stc_pkg::FRAC_HI)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!two_sided_reg)
                    begin
                        blocked_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (za_reg == zc_reg && zb_reg == zd_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (obot >= otop)
                    begin
                        blocked_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (za_reg != zc_reg)
                    begin
                        dn_next     = NW'(hb_diff) <<< 6;
                        dd_next     = DW'(f_cur);
                        dstart_next = 1'b1;
                        state_next  = ST_SLOPE_B;
                    end
                    else
                    begin
                        dn_next     = NW'(ht_diff) <<< 6;
                        dd_next     = DW'(f_cur);
                        dstart_next = 1'b1;
                        state_next  = ST_SLOPE_T;
                    end
                end
            end
            ST_SLOPE_B:
            begin
                if (div_done)
                begin
                    if (slope_new > bot_reg)
                    begin
                        bot_next = slope_new;
                    end
                    if (zb_reg != zd_reg)
                    begin
                        dn_next     = NW'(ht_diff) <<< 6;
                        dd_next     = DW'(f_reg);
                        dstart_next = 1'b1;
                        state_next  = ST_SLOPE_T;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_SLOPE_T:
            begin
                if (div_done)
                begin
                    if (slope_new < top_reg)
                    begin
                        top_next = slope_new;
                    end
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (top_reg <= bot_reg)
                begin
                    blocked_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eye_reg       <= '0;
            top_reg       <= '0;
            bot_reg       <= '0;
            lx_reg        <= '0;
            ly_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            blocked_reg   <= 1'b0;
            step_reg      <= '0;
            mstart_reg    <= 1'b0;
            dstart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eye_reg       <= eye_next;
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            lx_reg        <= lx_next;
            ly_reg        <= ly_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            blocked_reg   <= blocked_next;
            step_reg      <= step_next;
            mstart_reg    <= mstart_next;
            dstart_reg    <= dstart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg        <= ax;
            ay_reg        <= ay;
            bx_reg        <= bx;
            by_reg        <= by;
            two_sided_reg <= two_sided;
            za_reg        <= z_a;
            zb_reg        <= z_b;
            zc_reg        <= z_c;
            zd_reg        <= z_d;
        end
        if (state_reg == ST_MUL && mul_done)
        begin
            prod_reg[step_reg] <= mul_p;
        end
        if (state_reg == ST_DIVF && div_done)
        begin
            f_reg <= f_cur;
        end
        dn_reg <= dn_next;
        dd_reg <= dd_next;
        if (out_load)
        begin
            visible_reg <= !blocked_reg;
            top_out_reg <= top_reg;
            bot_out_reg <= bot_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign visible          = visible_reg;
    assign top_slope_out    = top_out_reg;
    assign bottom_slope_out = bot_out_reg;

    `STC_NEVER(a_units_excl, mul_busy && div_busy, "multiplier and divider active together")
    `STC_ASSERT(a_idle_quiet, (state_reg == ST_IDLE) |-> (!mul_busy && !div_busy), "unit busy while idle")
    `STC_ASSERT(a_blocked_hold, (accept && func && blocked_reg) |=> (state_reg == ST_DONE && $stable(top_reg) && $stable(bot_reg)), "blocked trace changed by segment")

endmodule

[dv/tb.sv]
// Testbench for sight_trace_segment_clipper_core: random and directed sight traces with checking.
// Depends on the clipper RTL; a built-in predictor computes the expected slopes.
`timescale 1ns / 100ps
module tb;

    typedef struct {
        logic               func;
        logic signed [15:0] ax, ay, bx, by;
        logic               two_sided;
        logic signed [31:0] z_a, z_b, z_c, z_d;
    } trace_item_t;

    typedef struct {
        logic               visible;
        logic signed [31:0] top_slope;
        logic signed [31:0] bottom_slope;
    } sight_result_t;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_SEGMENT = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic signed [15:0] ax, ay, bx, by;
    logic               two_sided;
    logic signed [31:0] z_a, z_b, z_c, z_d;
    logic               out_valid;
    logic               out_ready;
    logic               visible;
    logic signed [31:0] top_slope_out;
    logic signed [31:0] bottom_slope_out;

    trace_item_t   pending_items[$];
    sight_result_t expected_sight[$];
    int            errors;
    longint        cycle_count;
    logic          hold_off;

    longint        m_eye, m_top, m_bot, m_lx, m_ly, m_tx, m_ty;
    logic          m_blocked;

    sight_trace_segment_clipper_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .ax(ax), .ay(ay), .bx(bx), .by(by), .two_sided(two_sided),
        .z_a(z_a), .z_b(z_b), .z_c(z_c), .z_d(z_d),
        .out_valid(out_valid), .out_ready(out_ready), .visible(visible),
        .top_slope_out(top_slope_out), .bottom_slope_out(bottom_slope_out)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint snap_odd(input logic signed [15:0] c);
        logic signed [15:0] s;
        s = {c[15:1], 1'b1};
        return longint'(s);
    endfunction

    function automatic longint slope_toward(input longint h, input longint f);
        longint q;
        q = ((h - m_eye) * 64) / f;
        if (q > 64'sd8388607)
        begin
            return 64'sd2147483647;
        end
        if (q < -64'sd8388608)
        begin
            return -64'sd2147483648;
        end
        return q * 256;
    endfunction

    function automatic longint intercept_frac(input trace_item_t it);
        longint tdx, tdy, dx, dy, nx, ny, pr1, pr2, den;
        logic   side1, side2;
        tdx = m_tx - m_lx;
        tdy = m_ty - m_ly;
        dx = longint'(it.bx) - m_lx;
        dy = longint'(it.by) - m_ly;
        side2 = (tdy * dx) < (dy * tdx);
        dx = longint'(it.ax) - m_lx;
        dy = longint'(it.ay) - m_ly;
        side1 = (tdy * dx) < (dy * tdx);
        if (side1 == side2)
        begin
            return -1;
        end
        nx = longint'(it.ay) - longint'(it.by);
        ny = longint'(it.bx) - longint'(it.ax);
        pr1 = nx * dx + ny * dy;
        pr2 = nx * (m_tx - longint'(it.ax)) + ny * (m_ty - longint'(it.ay));
        den = pr1 + pr2;
        if (den == 0)
        begin
            return 0;
        end
        return clamp32((pr1 * 65536) / den);
    endfunction

    task automatic clip_segment(input trace_item_t it);
        longint frac, f, ff, fc, bf, bc, otop, obot, s;
        frac = intercept_frac(it);
        if (frac < 4 || frac >= 65537)
        begin
            return;
        end
        if (!it.two_sided)
        begin
            m_blocked = 1'b1;
            return;
        end
        ff = it.z_a;
        fc = it.z_b;
        bf = it.z_c;
        bc = it.z_d;
        if (ff == bf && fc == bc)
        begin
            return;
        end
        otop = (fc < bc) ? fc : bc;
        obot = (ff > bf) ? ff : bf;
        if (obot >= otop)
        begin
            m_blocked = 1'b1;
            return;
        end
        f = frac / 4;
        if (ff != bf)
        begin
            s = slope_toward(obot, f);
            if (s > m_bot)
            begin
                m_bot = s;
            end
        end
        if (fc != bc)
        begin
            s = slope_toward(otop, f);
            if (s < m_top)
            begin
                m_top = s;
            end
        end
        if (m_top <= m_bot)
        begin
            m_blocked = 1'b1;
        end
    endtask

    task automatic predict_sight(input trace_item_t it);
        sight_result_t r;
        longint        zb;
        if (it.func == FUNC_START)
        begin
            m_lx = snap_odd(it.ax);
            m_ly = snap_odd(it.ay);
            m_tx = snap_odd(it.bx);
            m_ty = snap_odd(it.by);
            zb = it.z_b;
            m_eye = clamp32(longint'(it.z_a) + zb - (zb >>> 2));
            m_top = clamp32(longint'(it.z_c) + longint'(it.z_d) - m_eye);
            m_bot = clamp32(longint'(it.z_c) - m_eye);
            m_blocked = 1'b0;
        end
        else if (!m_blocked)
        begin
            clip_segment(it);
        end
        r.visible = !m_blocked;
        r.top_slope = m_top[31:0];
        r.bottom_slope = m_bot[31:0];
        expected_sight.push_back(r);
    endtask

    function automatic logic calm_phase();
        return ((cycle_count / 3000) % 5) == 2;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (in_valid && in_ready)
            begin
                predict_sight(pending_items.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && (calm_phase() || $urandom_range(99) >= 15))
                begin
                    in_valid <= 1'b1;
                    func <= pending_items[0].func;
                    ax <= pending_items[0].ax;
                    ay <= pending_items[0].ay;
                    bx <= pending_items[0].bx;
                    by <= pending_items[0].by;
                    two_sided <= pending_items[0].two_sided;
                    z_a <= pending_items[0].z_a;
                    z_b <= pending_items[0].z_b;
                    z_c <= pending_items[0].z_c;
                    z_d <= pending_items[0].z_d;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !hold_off && (calm_phase() || $urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sight.size() == 0)
            begin
                $display("%0t: unexpected transfer: visible %0b top %0d bottom %0d",
                    $time, visible, top_slope_out, bottom_slope_out);
                errors++;
            end
            else
            begin
                sight_result_t e;
                e = expected_sight.pop_front();
                if (visible !== e.visible)
                begin
                    $display("%0t: visible expected %0b actual %0b", $time, e.visible, visible);
                    errors++;
                end
                if (top_slope_out !== e.top_slope)
                begin
                    $display("%0t: top slope expected %0d actual %0d",
                        $time, e.top_slope, top_slope_out);
                    errors++;
                end
                if (bottom_slope_out !== e.bottom_slope)
                begin
                    $display("%0t: bottom slope expected %0d actual %0d",
                        $time, e.bottom_slope, bottom_slope_out);
                    errors++;
                end
            end
        end
    end

    function automatic trace_item_t make_item(input logic f, input longint x0, input longint y0,
        input longint x1, input longint y1, input int ts, input longint za, input longint zb,
        input longint zc, input longint zd);
        trace_item_t it;
        it.func = f;
        it.ax = x0[15:0];
        it.ay = y0[15:0];
        it.bx = x1[15:0];
        it.by = y1[15:0];
        it.two_sided = ts[0];
        it.z_a = za[31:0];
        it.z_b = zb[31:0];
        it.z_c = zc[31:0];
        it.z_d = zd[31:0];
        return it;
    endfunction

    function automatic trace_item_t noise_item();
        trace_item_t it;
        it.func = 1'($urandom_range(1));
        it.ax = 16'($urandom);
        it.ay = 16'($urandom);
        it.bx = 16'($urandom);
        it.by = 16'($urandom);
        it.two_sided = 1'($urandom_range(1));
        it.z_a = $urandom;
        it.z_b = $urandom;
        it.z_c = $urandom;
        it.z_d = $urandom;
        return it;
    endfunction

    task automatic add_directed();
        longint u;
        u = 65536;
        pending_items.push_back(make_item(FUNC_SEGMENT, 5, -5, 5, 5, 0, 0, u, 0, u));
        pending_items.push_back(make_item(FUNC_START, 32767, 32767, 32767, 32767, 1,
            64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
        pending_items.push_back(make_item(FUNC_START, -32768, -32768, -32768, -32768, 0,
            -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
        pending_items.push_back(make_item(FUNC_START, -1000, 0, 1000, 0, 0,
            0, 40 * u, 0, 40 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, -100, 0, 100, 1,
            0, 100 * u, 0, 100 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, -999, -50, -999, 50, 1,
            0, 10 * u, 50 * u, 60 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, 0, 100, 0, 1,
            0, 10 * u, 50 * u, 60 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, -500, -100, -500, 100, 1,
            0, 100 * u, 10 * u, 100 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, -100, 0, 100, 1,
            0, 100 * u, 0, 60 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 500, -100, 500, 100, 1,
            0, 100 * u, 40 * u, 45 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 200, -100, 200, 100, 0,
            0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_START, -1000, 0, 1000, 0, 1,
            0, 40 * u, 0, 40 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, -100, 0, 100, 0,
            0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_SEGMENT, 300, -100, 300, 100, 1,
            0, 100 * u, 10 * u, 90 * u));
        pending_items.push_back(make_item(FUNC_START, -1000, 0, 1000, 0, 0,
            0, 40 * u, 0, 40 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, -100, 0, 100, 1,
            0, 100 * u, 70 * u, 90 * u));
        pending_items.push_back(make_item(FUNC_START, -1000, -1000, 1000, 1000, 0,
            0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_SEGMENT, 0, 2, 2, 0, 1,
            -5 * u, 5 * u, -3 * u, 3 * u));
        pending_items.push_back(make_item(FUNC_SEGMENT, -32768, 32767, 32767, -32768, 1,
            -64'sd2147483648, 64'sd2147483647, 0, 1));
    endtask

    task automatic add_random(input int count);
        longint lx, ly, tx, ty, mx, my, px, py, k, s, fl, ce, bfl, bce, u;
        int     n, segs;
        u = 65536;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(99) < 12)
            begin
                pending_items.push_back(noise_item());
                n++;
            end
            else
            begin
                lx = $signed($urandom_range(16000)) - 8000;
                ly = $signed($urandom_range(16000)) - 8000;
                tx = $signed($urandom_range(16000)) - 8000;
                ty = $signed($urandom_range(16000)) - 8000;
                pending_items.push_back(make_item(FUNC_START, lx, ly, tx, ty,
                    $urandom_range(1), $signed($urandom_range(64)) * u - 32 * u,
                    $urandom_range(64) * u, $signed($urandom_range(64)) * u - 32 * u,
                    $urandom_range(64) * u + $urandom_range(65535)));
                n++;
                segs = $urandom_range(12, 3);
                repeat (segs)
                begin
                    k = $urandom_range(15, 1);
                    mx = lx + (tx - lx) * k / 16;
                    my = ly + (ty - ly) * k / 16;
                    s = $urandom_range(64, 1);
                    px = -(ty - ly) * s / 256 + $signed($urandom_range(8)) - 4;
                    py = (tx - lx) * s / 256 + $signed($urandom_range(8)) - 4;
                    fl = ($signed($urandom_range(96)) - 48) * u + $urandom_range(65535);
                    ce = fl + $urandom_range(128) * u;
                    if ($urandom_range(3) == 0)
                    begin
                        bfl = fl;
                        bce = ce + $urandom_range(16) * u;
                    end
                    else
                    begin
                        bfl = ($signed($urandom_range(96)) - 48) * u + $urandom_range(65535);
                        bce = ($urandom_range(3) == 0) ? ce : bfl + $urandom_range(128) * u;
                    end
                    pending_items.push_back(make_item(FUNC_SEGMENT, mx - px, my - py,
                        mx + px, my + py, int'($urandom_range(9) != 0), fl, ce, bfl, bce));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        wait (expected_sight.size() > 0);
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        repeat (4000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        errors = 0;
        m_eye = 0;
        m_top = 0;
        m_bot = 0;
        m_lx = 0;
        m_ly = 0;
        m_tx = 0;
        m_ty = 0;
        m_blocked = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = 1'b0;
        ax = '0;
        ay = '0;
        bx = '0;
        by = '0;
        two_sided = 1'b0;
        z_a = '0;
        z_b = '0;
        z_c = '0;
        z_d = '0;
        add_directed();
        add_random(1800);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() > 0 || in_valid || expected_sight.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (500) @(posedge clk);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
